@@ rtl/csv_line_tokenizer_assert.svh @@
// assertion macros for the csv line tokenizer checker
// expects clk and rst_n in the scope where a macro is used
`ifndef CSV_LINE_TOKENIZER_ASSERT_SVH
`define CSV_LINE_TOKENIZER_ASSERT_SVH

// same-cycle implication, off during reset
`define CSV_TOK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CSV_TOK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked during reset
`define CSV_TOK_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/csv_tok_pkg.sv @@
// types, character codes and helpers shared by the csv line tokenizer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package csv_tok_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_TEXT    = 2'd0,
    KIND_INTEGER = 2'd1,
    KIND_DECIMAL = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_field_end;
    logic [1:0] field_kind;
    logic       record_end;
  } res_t;

  // results produced by one accepted byte, first slot delivered first
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic kind_t kind_of(input logic quoted, input logic has_dot);
    kind_t k;
    if (quoted) begin
      k = KIND_TEXT;
    end else if (has_dot) begin
      k = KIND_DECIMAL;
    end else begin
      k = KIND_INTEGER;
    end
    return k;
  endfunction

  function automatic res_t content_res(input logic [7:0] b);
    res_t r;
    r.out_byte     = b;
    r.is_field_end = 1'b0;
    r.field_kind   = KIND_TEXT;
    r.record_end   = 1'b0;
    return r;
  endfunction

  function automatic res_t field_end_res(input kind_t k);
    res_t r;
    r.out_byte     = 8'h00;
    r.is_field_end = 1'b1;
    r.field_kind   = k;
    r.record_end   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/csv_tok_if.sv @@
// handshake channels of the csv line tokenizer: byte input and result output
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface csv_tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_line;

  modport source (output valid, output in_byte, output end_of_line, input ready);
  modport sink (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface csv_tok_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_field_end;
  logic [1:0] field_kind;
  logic       record_end;

  modport source (output valid, output out_byte, output is_field_end,
                  output field_kind, output record_end, input ready);
  modport sink (input valid, input out_byte, input is_field_end,
                input field_kind, input record_end, output ready);
endinterface

`default_nettype wire

@@ rtl/csv_tok_core.sv @@
// quoting and field state of the tokenizer, one byte per accepted transaction
// depends on csv_tok_pkg
`timescale 1ns / 1ps
`default_nettype none

module csv_tok_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [7:0]          in_byte,
  input  wire logic                end_of_line,
  output csv_tok_pkg::push_t       push
);
  import csv_tok_pkg::*;

  logic inside_quotes_r, inside_quotes_nxt;
  logic quote_pending_r, quote_pending_nxt;
  logic field_was_quoted_r, field_was_quoted_nxt;
  logic field_has_dot_r, field_has_dot_nxt;
  logic field_nonempty_r, field_nonempty_nxt;

  logic is_quote, is_comma, is_dot;
  logic consumed, inq;
  logic have_a, have_b;
  res_t res_a, res_b;
  logic q1, d1, ne1;
  logic [1:0] n;

  assign is_quote = (in_byte == CH_QUOTE);
  assign is_comma = (in_byte == CH_COMMA);
  assign is_dot   = (in_byte == CH_DOT);

  always_comb begin
    consumed = quote_pending_r && is_quote;
    inq      = (quote_pending_r && !is_quote) ? 1'b0 : inside_quotes_r;
    inside_quotes_nxt = inq;
    quote_pending_nxt = 1'b0;
    q1    = field_was_quoted_r;
    d1    = field_has_dot_r;
    ne1   = field_nonempty_r;
    have_a = 1'b0;
    res_a  = content_res(in_byte);
    have_b = 1'b0;
    res_b  = field_end_res(KIND_TEXT);

    // byte step
    if (consumed) begin
      have_a = 1'b1;
      ne1    = 1'b1;
    end else if (is_quote) begin
      if (inq) begin
        if (end_of_line) begin
          inside_quotes_nxt = 1'b0;
        end else begin
          quote_pending_nxt = 1'b1;
        end
      end else begin
        inside_quotes_nxt = 1'b1;
        q1 = 1'b1;
      end
    end else if (!inq && is_comma) begin
      have_a = 1'b1;
      res_a  = field_end_res(kind_of(field_was_quoted_r, field_has_dot_r));
      q1  = 1'b0;
      d1  = 1'b0;
      ne1 = 1'b0;
    end else begin
      have_a = 1'b1;
      ne1    = 1'b1;
      d1     = field_has_dot_r | is_dot;
    end

    field_was_quoted_nxt = q1;
    field_has_dot_nxt    = d1;
    field_nonempty_nxt   = ne1;

    // line end closes the field and clears all state
    if (end_of_line) begin
      if (ne1 || q1) begin
        have_b = 1'b1;
        res_b  = field_end_res(kind_of(q1, d1));
        res_b.record_end = 1'b1;
      end else begin
        res_a.record_end = 1'b1;
      end
      inside_quotes_nxt    = 1'b0;
      quote_pending_nxt    = 1'b0;
      field_was_quoted_nxt = 1'b0;
      field_has_dot_nxt    = 1'b0;
      field_nonempty_nxt   = 1'b0;
    end

    n = {1'b0, have_a} + {1'b0, have_b};
    push.cnt    = accept ? n : 2'd0;
    push.first  = have_a ? res_a : res_b;
    push.second = res_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_quotes_r    <= 1'b0;
      quote_pending_r    <= 1'b0;
      field_was_quoted_r <= 1'b0;
      field_has_dot_r    <= 1'b0;
      field_nonempty_r   <= 1'b0;
    end else if (accept) begin
      inside_quotes_r    <= inside_quotes_nxt;
      quote_pending_r    <= quote_pending_nxt;
      field_was_quoted_r <= field_was_quoted_nxt;
      field_has_dot_r    <= field_has_dot_nxt;
      field_nonempty_r   <= field_nonempty_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/csv_tok_outq.sv @@
// result queue: takes up to two results a cycle, hands out one per transaction
// depends on csv_tok_pkg
`timescale 1ns / 1ps
`default_nettype none

module csv_tok_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  csv_tok_pkg::push_t       push,
  output logic                     room,
  output logic                     head_valid,
  output csv_tok_pkg::res_t        head,
  input  wire logic                pop
);
  import csv_tok_pkg::*;

  res_t             mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic [QAW-1:0]   wr_ptr_1;
  logic             do_pop;

  // two free entries needed for the worst case push
  assign room       = (count_r <= QCW'(QDEPTH - 2));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;
  assign wr_ptr_1   = wr_ptr_r + QAW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QAW'(do_pop);
    count_nxt  = count_r + QCW'(push.cnt) - QCW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_1] <= push.second;
    end
  end

endmodule

`default_nettype wire

@@ rtl/csv_line_tokenizer.sv @@
// csv line tokenizer: one byte per cycle in, content bytes and field-end markers out
// a result is written to the result queue when its byte is taken, then offered on out_ch
// one byte per cycle while ready; a byte with two results gives two transactions
// in_ch.ready drops while the four-entry result queue has fewer than two free slots
// reset (rst_n low, synchronous) clears quoting state and empties the queue
`timescale 1ns / 1ps
`default_nettype none

module csv_line_tokenizer (
  input  wire logic     clk,
  input  wire logic     rst_n,
  csv_tok_in_if.sink    in_ch,
  csv_tok_out_if.source out_ch
);
  import csv_tok_pkg::*;

  logic  room;
  logic  accept;
  logic  head_valid;
  res_t  head;
  push_t push;

  assign in_ch.ready = room;
  assign accept      = in_ch.valid && room;

  csv_tok_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_ch.in_byte),
    .end_of_line (in_ch.end_of_line),
    .push        (push)
  );

  csv_tok_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_ch.ready)
  );

  assign out_ch.valid        = head_valid;
  assign out_ch.out_byte     = head.out_byte;
  assign out_ch.is_field_end = head.is_field_end;
  assign out_ch.field_kind   = head.field_kind;
  assign out_ch.record_end   = head.record_end;

endmodule

`default_nettype wire

@@ rtl/csv_tok_chk.sv @@
// port-level checks for the csv line tokenizer, bound to the top level
// depends on csv_tok_pkg and csv_line_tokenizer_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "csv_line_tokenizer_assert.svh"

module csv_tok_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       is_field_end,
  input wire logic [1:0] field_kind,
  input wire logic       record_end
);
  import csv_tok_pkg::*;

  // stalled result transaction holds its payload
  `CSV_TOK_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(is_field_end) && $stable(field_kind) && $stable(record_end), "result changed while stalled")

  // content bytes carry no kind
  `CSV_TOK_ASSERT_IMP(a_content_kind, out_valid && !is_field_end, field_kind == KIND_TEXT, "content result with nonzero kind")

  // field-end markers carry a zero byte
  `CSV_TOK_ASSERT_IMP(a_end_byte, out_valid && is_field_end, out_byte == 8'h00, "field end with nonzero byte")

  // queue is empty right after reset
  `CSV_TOK_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "result offered after reset")

endmodule

bind csv_line_tokenizer csv_tok_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .is_field_end (out_ch.is_field_end),
  .field_kind   (out_ch.field_kind),
  .record_end   (out_ch.record_end)
);

`default_nettype wire

@@ test/tb_csv_line_tokenizer.sv @@
// testbench for csv_line_tokenizer: directed csv lines, then random lines with random idling
// predicts the token stream in a scoreboard class and checks every output transaction
// depends on rtl/csv_tok_pkg.sv, rtl/csv_tok_if.sv and rtl/csv_line_tokenizer.sv
`timescale 1ns / 1ps

module tb_csv_line_tokenizer;
  import csv_tok_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TARGET_BYTES = 1800;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 400;

  class csv_token_board;
    res_t pending_tokens[$];
    int   errors;
    bit   in_quotes;
    bit   quote_held;
    bit   was_quoted;
    bit   has_dot;
    bit   nonempty;
    res_t made[2];
    int   made_n;

    function void add_content(logic [7:0] b);
      made[made_n].out_byte     = b;
      made[made_n].is_field_end = 1'b0;
      made[made_n].field_kind   = KIND_TEXT;
      made[made_n].record_end   = 1'b0;
      made_n++;
      nonempty = 1'b1;
      if (b == CH_DOT) begin
        has_dot = 1'b1;
      end
    endfunction

    function void add_field_end();
      kind_t k;
      if (was_quoted) begin
        k = KIND_TEXT;
      end else if (has_dot) begin
        k = KIND_DECIMAL;
      end else begin
        k = KIND_INTEGER;
      end
      made[made_n].out_byte     = 8'h00;
      made[made_n].is_field_end = 1'b1;
      made[made_n].field_kind   = k;
      made[made_n].record_end   = 1'b0;
      made_n++;
      was_quoted = 1'b0;
      has_dot    = 1'b0;
      nonempty   = 1'b0;
    endfunction

    // tokenize one accepted byte and queue the tokens it yields
    function void note_byte(logic [7:0] b, logic eol);
      bit taken;
      taken  = 1'b0;
      made_n = 0;
      if (quote_held) begin
        quote_held = 1'b0;
        if (b == CH_QUOTE) begin
          add_content(b);
          taken = 1'b1;
        end else begin
          in_quotes = 1'b0;
        end
      end
      if (!taken) begin
        if (b == CH_QUOTE) begin
          if (in_quotes) begin
            if (eol) begin
              in_quotes = 1'b0;
            end else begin
              quote_held = 1'b1;
            end
          end else begin
            in_quotes  = 1'b1;
            was_quoted = 1'b1;
          end
        end else if (!in_quotes && b == CH_COMMA) begin
          add_field_end();
        end else begin
          add_content(b);
        end
      end
      if (eol) begin
        if (nonempty || was_quoted) begin
          add_field_end();
        end
        if (made_n > 0) begin
          made[made_n - 1].record_end = 1'b1;
        end
        in_quotes  = 1'b0;
        quote_held = 1'b0;
        was_quoted = 1'b0;
        has_dot    = 1'b0;
        nonempty   = 1'b0;
      end
      for (int i = 0; i < made_n; i++) begin
        pending_tokens.push_back(made[i]);
      end
    endfunction

    function void check_token(res_t got);
      res_t want;
      if (pending_tokens.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected token: byte %02h end %0b kind %0d rec %0b",
                   got.out_byte, got.is_field_end, got.field_kind, got.record_end);
        end
      end else begin
        want = pending_tokens.pop_front();
        if (got.out_byte !== want.out_byte || got.is_field_end !== want.is_field_end ||
            got.field_kind !== want.field_kind || got.record_end !== want.record_end) begin
          errors++;
          if (errors <= 10) begin
            $write("token mismatch: expected byte %02h end %0b kind %0d rec %0b,",
                   want.out_byte, want.is_field_end, want.field_kind, want.record_end);
            $display(" got byte %02h end %0b kind %0d rec %0b",
                     got.out_byte, got.is_field_end, got.field_kind, got.record_end);
          end
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   bytes_sent = 0;
  bit   steady = 1'b0;
  bit   hold_request = 1'b0;
  bit   hold_active = 1'b0;
  logic [7:0] line_buf[$];
  csv_token_board board;

  csv_tok_in_if  in_ch ();
  csv_tok_out_if out_ch ();

  csv_line_tokenizer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** csv_line_tokenizer: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_QUOTE || b == CH_COMMA);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      return CH_QUOTE;
    end else if (r < 30) begin
      return CH_COMMA;
    end else if (r < 40) begin
      return CH_DOT;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eol);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.in_byte     = b;
    in_ch.end_of_line = eol;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    board.note_byte(b, eol);
    bytes_sent++;
    if (bytes_sent == HOLD_AT) begin
      hold_request = 1'b1;
    end
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  task automatic add_field(input bit last);
    int sel;
    int len;
    int r;
    sel = $urandom_range(0, 9);
    len = $urandom_range(1, 6);
    if (sel >= 1 && sel <= 3) begin
      repeat (len) line_buf.push_back(digit_byte());
    end else if (sel == 4 || sel == 5) begin
      for (int i = 0; i < len; i++) begin
        line_buf.push_back(($urandom_range(0, 3) == 0) ? CH_DOT : digit_byte());
      end
      line_buf.push_back(CH_DOT);
      line_buf.push_back(digit_byte());
    end else if (sel == 6) begin
      repeat (len) line_buf.push_back(plain_byte());
    end else if (sel >= 7) begin
      line_buf.push_back(CH_QUOTE);
      len = $urandom_range(0, 6);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          line_buf.push_back(CH_QUOTE);
          line_buf.push_back(CH_QUOTE);
        end else if (r < 30) begin
          line_buf.push_back(CH_COMMA);
        end else if (r < 40) begin
          line_buf.push_back(CH_DOT);
        end else begin
          line_buf.push_back(plain_byte());
        end
      end
      if (!(last && $urandom_range(0, 7) == 0)) begin
        line_buf.push_back(CH_QUOTE);
        if ($urandom_range(0, 9) == 0) begin
          line_buf.push_back(plain_byte());
        end
      end
    end
  endtask

  task automatic build_line();
    int nf;
    int n;
    line_buf.delete();
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 12);
      repeat (n) line_buf.push_back(noise_byte());
    end else begin
      nf = $urandom_range(1, 5);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) begin
          line_buf.push_back(CH_COMMA);
        end
        add_field(f == nf - 1);
      end
      if ($urandom_range(0, 9) == 0) begin
        line_buf.push_back(CH_COMMA);
      end
      if (line_buf.size() == 0) begin
        line_buf.push_back(digit_byte());
      end
    end
  endtask

  // long receiver hold-off, counted in cycles
  initial begin
    wait (hold_request === 1'b1);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  // result side: random stalls, no-stall stretches and the long hold-off
  initial begin
    int stall_left;
    res_t got;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_active) begin
        out_ch.ready = 1'b0;
      end else if (steady) begin
        out_ch.ready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
        stall_left   = pick_gap();
      end
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        got.out_byte     = out_ch.out_byte;
        got.is_field_end = out_ch.is_field_end;
        got.field_kind   = out_ch.field_kind;
        got.record_end   = out_ch.record_end;
        board.check_token(got);
      end
    end
  end

  initial begin
    board             = new();
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = 8'h00;
    in_ch.end_of_line = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // doubled quote, text, decimal, empty integer field, trailing comma
    send_text("\"a\"\"b\",1.5,,");
    // quote in mid field, left open at line end
    send_text("x\"y");
    // empty quoted field
    send_text("\"\"");
    // pending quote closed by the last byte
    send_text("\"a\"z");
    // pending quote paired by the last byte
    send_text("\"\"\"");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    while (bytes_sent < TARGET_BYTES) begin
      steady = (bytes_sent >= 300 && bytes_sent < 450) ||
               (bytes_sent >= 1200 && bytes_sent < 1300);
      build_line();
      for (int i = 0; i < line_buf.size(); i++) begin
        send_byte(line_buf[i], i == line_buf.size() - 1);
      end
    end
    steady      = 1'b0;
    in_ch.valid = 1'b0;

    while (board.pending_tokens.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);

    if (board.pending_tokens.size() != 0) begin
      board.errors += board.pending_tokens.size();
      $display("%0d expected tokens never arrived", board.pending_tokens.size());
    end
    if (board.errors == 0) begin
      $display("** csv_line_tokenizer: PASSED **");
    end else begin
      $display("** csv_line_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/csv_tok_pkg.sv
rtl/csv_tok_if.sv
rtl/csv_tok_core.sv
rtl/csv_tok_outq.sv
rtl/csv_line_tokenizer.sv
rtl/csv_tok_chk.sv
test/tb_csv_line_tokenizer.sv
